FILE: rtl/core/dnr_pkg.sv
// Shared types, constants and ramp tables for the depth normalize color ramp.
// Used by dnr_level, dnr_ramp and depth_normalize_color_ramp; no dependencies.
package dnr_pkg;

    localparam int SAMPLE_BITS   = 32;
    localparam int FRACTION_BITS = 16;

    localparam int PORT_BITS  = 32;
    localparam int RECIP_BITS = 32;
    localparam int DIFF_BITS  = SAMPLE_BITS + 1;
    localparam int PROD_BITS  = SAMPLE_BITS + RECIP_BITS;

    localparam int LEVEL_BITS = 17;
    localparam logic [LEVEL_BITS-1:0] LEVEL_ONE = 17'h10000;

    localparam int STOP_COUNT = 5;
    localparam int CHANNELS   = 3;
    localparam int COMP_BITS  = 7;
    localparam int MIX_BITS   = 23;
    localparam int SCALED_BITS = MIX_BITS + 8;
    localparam int QUOT_BITS  = 15;

    // Division by 100 as a multiply by a rounded-up reciprocal and a shift.
    localparam int DIV_MUL_BITS = 13;
    localparam logic [DIV_MUL_BITS-1:0] DIV_MUL = 13'd5243;
    localparam int DIV_SHIFT    = 19;
    localparam int DIV_PROD_BITS = QUOT_BITS + DIV_MUL_BITS;

    typedef logic [COMP_BITS-1:0] dnr_comp_t;

    // Stop colors in hundredths: red, green, blue.
    localparam dnr_comp_t RAMP_STOPS [STOP_COUNT][CHANNELS] = '{
        '{7'd5,   7'd3,   7'd20},
        '{7'd10,  7'd42,  7'd62},
        '{7'd16,  7'd72,  7'd55},
        '{7'd85,  7'd72,  7'd20},
        '{7'd100, 7'd100, 7'd96}
    };

    typedef enum logic [1:0] {
        CFG_RANGE_LOW    = 2'd0,
        CFG_SPAN_RECIP   = 2'd1,
        CFG_INVERT_LEVEL = 2'd2
    } dnr_cfg_t;

    typedef struct packed {
        logic load_a;
        logic load_b;
        logic load_c;
    } dnr_step_t;

endpackage

FILE: rtl/core/dnr_level.sv
// Level half of the pipeline: difference, reciprocal multiply, clamp, optional inversion and split.
// Three register stages; depends on dnr_pkg.
module dnr_level
    import dnr_pkg::*;
(
    input  logic                  clk,
    input  dnr_step_t             step,
    input  logic [PORT_BITS-1:0]  depth_sample,
    input  logic [PORT_BITS-1:0]  range_low,
    input  logic [RECIP_BITS-1:0] span_recip,
    input  logic                  invert_level,
    output logic [LEVEL_BITS-1:0] level,
    output logic [1:0]            seg,
    output logic [LEVEL_BITS-1:0] frac
);

    logic signed [DIFF_BITS-1:0] sample_ext;
    logic signed [DIFF_BITS-1:0] low_ext;
    logic signed [DIFF_BITS-1:0] diff;
    logic [SAMPLE_BITS-1:0]      mag_next;
    logic [SAMPLE_BITS-1:0]      mag_reg;
    logic [PROD_BITS-1:0]        prod_next;
    logic [PROD_BITS-1:0]        prod_reg;
    logic [LEVEL_BITS-1:0]       clamp_level;
    logic [LEVEL_BITS-1:0]       level_next;
    logic [LEVEL_BITS-1:0]       level_reg;
    logic [1:0]                  seg_next;
    logic [1:0]                  seg_reg;
    logic [LEVEL_BITS-1:0]       frac_next;
    logic [LEVEL_BITS-1:0]       frac_reg;

    always_comb
    begin
        sample_ext = DIFF_BITS'($signed(depth_sample[SAMPLE_BITS-1:0]));
        low_ext    = DIFF_BITS'($signed(range_low[SAMPLE_BITS-1:0]));
        diff       = sample_ext - low_ext;
        if (!diff[DIFF_BITS-1])
        begin
            mag_next = diff[SAMPLE_BITS-1:0];
        end
        else
        begin
            mag_next = '0;
        end
    end

    assign prod_next = PROD_BITS'(mag_reg) * PROD_BITS'(span_recip);

    always_comb
    begin
        if ((|prod_reg[PROD_BITS-1:FRACTION_BITS+LEVEL_BITS]) ||
            (prod_reg[FRACTION_BITS+LEVEL_BITS-1:FRACTION_BITS] > LEVEL_ONE))
        begin
            clamp_level = LEVEL_ONE;
        end
        else
        begin
            clamp_level = prod_reg[FRACTION_BITS+LEVEL_BITS-1:FRACTION_BITS];
        end
        if (invert_level)
        begin
            level_next = LEVEL_ONE - clamp_level;
        end
        else
        begin
            level_next = clamp_level;
        end
        if (level_next[LEVEL_BITS-1])
        begin
            seg_next  = 2'd3;
            frac_next = LEVEL_ONE;
        end
        else
        begin
            seg_next  = level_next[15:14];
            frac_next = {1'b0, level_next[13:0], 2'b00};
        end
    end

    always_ff @(posedge clk)
    begin
        if (step.load_a)
        begin
            mag_reg <= mag_next;
        end
        if (step.load_b)
        begin
            prod_reg <= prod_next;
        end
        if (step.load_c)
        begin
            level_reg <= level_next;
            seg_reg   <= seg_next;
            frac_reg  <= frac_next;
        end
    end

    assign level = level_reg;
    assign seg   = seg_reg;
    assign frac  = frac_reg;

endmodule

FILE: rtl/core/dnr_ramp.sv
// Color half of the pipeline: segment interpolation, scale by 255, divide by 100.
// Three register stages for all three channels; depends on dnr_pkg.
module dnr_ramp
    import dnr_pkg::*;
(
    input  logic                  clk,
    input  dnr_step_t             step,
    input  logic [LEVEL_BITS-1:0] level,
    input  logic [1:0]            seg,
    input  logic [LEVEL_BITS-1:0] frac,
    output logic [LEVEL_BITS-1:0] norm_level,
    output logic [7:0]            red,
    output logic [7:0]            green,
    output logic [7:0]            blue
);

    logic [2:0]               seg_lo;
    logic [2:0]               seg_hi;
    logic [LEVEL_BITS-1:0]    frac_inv;
    logic [MIX_BITS-1:0]      mix_next [CHANNELS];
    logic [MIX_BITS-1:0]      mix_reg [CHANNELS];
    logic [SCALED_BITS-1:0]   scaled [CHANNELS];
    logic [QUOT_BITS-1:0]     quot_next [CHANNELS];
    logic [QUOT_BITS-1:0]     quot_reg [CHANNELS];
    logic [DIV_PROD_BITS-1:0] div_prod [CHANNELS];
    logic [7:0]               byte_next [CHANNELS];
    logic [7:0]               byte_reg [CHANNELS];
    logic [LEVEL_BITS-1:0]    level_a_reg;
    logic [LEVEL_BITS-1:0]    level_b_reg;
    logic [LEVEL_BITS-1:0]    level_c_reg;

    always_comb
    begin
        seg_lo   = {1'b0, seg};
        seg_hi   = {1'b0, seg} + 3'd1;
        frac_inv = LEVEL_ONE - frac;
        for (int c = 0; c < CHANNELS; c++)
        begin
            mix_next[c] = MIX_BITS'(RAMP_STOPS[seg_lo][c]) * MIX_BITS'(frac_inv)
                        + MIX_BITS'(RAMP_STOPS[seg_hi][c]) * MIX_BITS'(frac);
            scaled[c]    = {mix_reg[c], 8'd0} - SCALED_BITS'(mix_reg[c]);
            quot_next[c] = scaled[c][SCALED_BITS-1:16];
            div_prod[c]  = DIV_PROD_BITS'(quot_reg[c]) * DIV_PROD_BITS'(DIV_MUL);
            byte_next[c] = div_prod[c][DIV_SHIFT+7:DIV_SHIFT];
        end
    end

    always_ff @(posedge clk)
    begin
        if (step.load_a)
        begin
            mix_reg     <= mix_next;
            level_a_reg <= level;
        end
        if (step.load_b)
        begin
            quot_reg    <= quot_next;
            level_b_reg <= level_a_reg;
        end
        if (step.load_c)
        begin
            byte_reg    <= byte_next;
            level_c_reg <= level_b_reg;
        end
    end

    assign norm_level = level_c_reg;
    assign red        = byte_reg[0];
    assign green      = byte_reg[1];
    assign blue       = byte_reg[2];

endmodule

FILE: rtl/core/depth_normalize_color_ramp.sv
// Top level of the depth normalize color ramp: configuration registers and
// pipeline flow control. Depends on dnr_pkg, dnr_level and dnr_ramp.
//
// Each request on the input channel carries one signed fixed-point depth
// sample and yields exactly one request on the output channel with the
// clamped normalized level and the red, green and blue ramp bytes.
// A request is taken at a rising edge where valid is high and stall is low.
// The datapath is six register stages deep: three in dnr_level, then three
// in dnr_ramp. One sample is accepted every cycle while the output is not
// stalled; the rate is set by the per-stage valid chain.
// When the receiver stalls, the last stage holds its result and each earlier
// stage keeps moving until it meets a full stage, so bubbles are squeezed
// out and input stall rises only once the whole pipeline is full.
// Configuration is written through cfg_write, cfg_index and cfg_data while
// no request is in flight; writes to an unknown index are ignored.
// Reset clears all valid bits and loads range low 0, reciprocal span 1.0
// and no inversion.
module depth_normalize_color_ramp
    import dnr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [PORT_BITS-1:0]  depth_sample,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [LEVEL_BITS-1:0] norm_level,
    output logic [7:0]            red,
    output logic [7:0]            green,
    output logic [7:0]            blue,
    input  logic                  cfg_write,
    input  logic [1:0]            cfg_index,
    input  logic [PORT_BITS-1:0]  cfg_data
);

    localparam int STAGES = 6;

    logic [PORT_BITS-1:0]  range_low_reg;
    logic [RECIP_BITS-1:0] span_recip_reg;
    logic                  invert_level_reg;
    logic [STAGES-1:0]     valid_reg;
    logic [STAGES-1:0]     load;
    dnr_step_t             level_step;
    dnr_step_t             ramp_step;
    logic [LEVEL_BITS-1:0] level;
    logic [1:0]            seg;
    logic [LEVEL_BITS-1:0] frac;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_low_reg    <= '0;
            span_recip_reg   <= 32'h0001_0000;
            invert_level_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (dnr_cfg_t'(cfg_index))
                CFG_RANGE_LOW:    range_low_reg    <= cfg_data;
                CFG_SPAN_RECIP:   span_recip_reg   <= cfg_data[RECIP_BITS-1:0];
                CFG_INVERT_LEVEL: invert_level_reg <= cfg_data[0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        load[STAGES-1] = !valid_reg[STAGES-1] || !out_stall;
        for (int i = STAGES - 2; i >= 0; i--)
        begin
            load[i] = !valid_reg[i] || load[i+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (load[0])
            begin
                valid_reg[0] <= in_valid;
            end
            for (int i = 1; i < STAGES; i++)
            begin
                if (load[i])
                begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    assign level_step = '{load_a: load[0], load_b: load[1], load_c: load[2]};
    assign ramp_step  = '{load_a: load[3], load_b: load[4], load_c: load[5]};

    dnr_level u_level (
        .clk          (clk),
        .step         (level_step),
        .depth_sample (depth_sample),
        .range_low    (range_low_reg),
        .span_recip   (span_recip_reg),
        .invert_level (invert_level_reg),
        .level        (level),
        .seg          (seg),
        .frac         (frac)
    );

    dnr_ramp u_ramp (
        .clk        (clk),
        .step       (ramp_step),
        .level      (level),
        .seg        (seg),
        .frac       (frac),
        .norm_level (norm_level),
        .red        (red),
        .green      (green),
        .blue       (blue)
    );

    assign in_stall  = !load[0];
    assign out_valid = valid_reg[STAGES-1];

endmodule

FILE: sim/depth_normalize_color_ramp_test.sv
// Testbench for depth_normalize_color_ramp: random and corner depth samples
// under several register settings and flow-control patterns, checked against
// a local pixel predictor. Depends on dnr_pkg and the RTL of the block.

typedef struct packed {
    logic [16:0] level;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
} ramp_pixel_t;

class ramp_scoreboard;
    logic [31:0]    range_low;
    logic [31:0]    span_recip;
    logic           invert_level;
    int unsigned    stop_pct [5][3];
    ramp_pixel_t    expected_pixels [$];
    int             mismatches;

    function new();
        range_low    = 32'd0;
        span_recip   = 32'd65536;
        invert_level = 1'b0;
        mismatches   = 0;
        stop_pct     = '{'{5, 3, 20}, '{10, 42, 62}, '{16, 72, 55},
                         '{85, 72, 20}, '{100, 100, 96}};
    endfunction

    function void set_register(logic [1:0] index, logic [31:0] value);
        case (index)
            dnr_pkg::CFG_RANGE_LOW:    range_low = value;
            dnr_pkg::CFG_SPAN_RECIP:   span_recip = value;
            dnr_pkg::CFG_INVERT_LEVEL: invert_level = value[0];
            default: ;
        endcase
    endfunction

    function ramp_pixel_t predict_pixel(logic [31:0] sample);
        longint            diff;
        longint unsigned   product;
        longint unsigned   level;
        longint unsigned   scaled;
        longint unsigned   segment;
        longint unsigned   frac;
        longint unsigned   mix;
        logic [7:0]        bytes [3];
        ramp_pixel_t       pixel;
        diff = longint'($signed(sample)) - longint'($signed(range_low));
        level = 0;
        if (diff > 0)
        begin
            product = longint'(diff) * {32'd0, span_recip};
            level = product >> 16;
            if (level > 65536)
                level = 65536;
        end
        if (invert_level)
            level = 65536 - level;
        scaled = level * 4;
        segment = scaled >> 16;
        if (segment > 3)
            segment = 3;
        frac = scaled - segment * 65536;
        for (int c = 0; c < 3; c++)
        begin
            mix = stop_pct[segment][c] * (65536 - frac) + stop_pct[segment + 1][c] * frac;
            bytes[c] = 8'((mix * 255) / 6553600);
        end
        pixel.level = 17'(level);
        pixel.red   = bytes[0];
        pixel.green = bytes[1];
        pixel.blue  = bytes[2];
        return pixel;
    endfunction

    function void note_sample(logic [31:0] sample);
        expected_pixels.push_back(predict_pixel(sample));
    endfunction

    function int pending();
        return expected_pixels.size();
    endfunction

    function void check_pixel(logic [16:0] level, logic [7:0] red, logic [7:0] green,
                              logic [7:0] blue);
        ramp_pixel_t want;
        if (expected_pixels.size() == 0)
        begin
            $error("unexpected result: norm_level %0d red %0d green %0d blue %0d",
                   level, red, green, blue);
            mismatches++;
            return;
        end
        want = expected_pixels.pop_front();
        if (level !== want.level)
        begin
            $error("norm_level expected %0d got %0d", want.level, level);
            mismatches++;
        end
        if (red !== want.red)
        begin
            $error("red expected %0d got %0d", want.red, red);
            mismatches++;
        end
        if (green !== want.green)
        begin
            $error("green expected %0d got %0d", want.green, green);
            mismatches++;
        end
        if (blue !== want.blue)
        begin
            $error("blue expected %0d got %0d", want.blue, blue);
            mismatches++;
        end
    endfunction
endclass

module depth_normalize_color_ramp_test;

    localparam logic [1:0] CFG_NO_REGISTER = 2'd3;
    localparam int         SETTLE_CYCLES   = 12;
    localparam int         QUIET_LIMIT     = 4000;
    localparam int         PHASES          = 8;
    localparam int         ITEMS_PER_PHASE = 125;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        in_valid     = 1'b0;
    logic        in_stall;
    logic [31:0] depth_sample = 32'd0;
    logic        out_valid;
    logic        out_stall    = 1'b0;
    logic [16:0] norm_level;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        cfg_write    = 1'b0;
    logic [1:0]  cfg_index    = 2'd0;
    logic [31:0] cfg_data     = 32'd0;

    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;
    int quiet_cycles = 0;
    ramp_scoreboard pixels = new();

    depth_normalize_color_ramp u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .depth_sample (depth_sample),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .norm_level   (norm_level),
        .red          (red),
        .green        (green),
        .blue         (blue),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(negedge clk)
    begin
        out_stall <= (receiver_stall_pct > 0) && ($urandom_range(99) < receiver_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                pixels.note_sample(depth_sample);
            end
            if (out_valid && !out_stall)
            begin
                pixels.check_pixel(norm_level, red, green, blue);
            end
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
            begin
                quiet_cycles <= 0;
            end
            else
            begin
                quiet_cycles <= quiet_cycles + 1;
            end
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    task automatic send_sample(input logic [31:0] value);
        @(negedge clk);
        while (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct)
        begin
            in_valid     <= 1'b0;
            depth_sample <= $urandom;
            @(negedge clk);
        end
        in_valid     <= 1'b1;
        depth_sample <= value;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic wait_for_results();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pixels.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [1:0] index, input logic [31:0] value);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        pixels.set_register(index, value);
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    function automatic logic [31:0] pick_sample(logic [31:0] low, longint span);
        longint base;
        longint offset;
        int     roll;
        base = longint'($signed(low));
        roll = $urandom_range(99);
        if (roll < 70)
            offset = (longint'({$urandom, $urandom}) & 64'h7FFF_FFFF_FFFF_FFFF)
                     % (span + span / 4 + 1) - span / 8;
        else if (roll < 85)
            offset = span * longint'($urandom_range(4)) / 4
                     + longint'($urandom_range(8)) - 4;
        else
            return $urandom;
        return 32'(base + offset);
    endfunction

    initial
    begin
        logic [31:0] corner_samples [18];
        logic [31:0] low;
        logic [31:0] recip;
        logic        invert;
        longint      span;
        int          shift;
        corner_samples = '{32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h8000_0000,
                           32'h7FFF_FFFF, 32'h0001_0000, 32'h0000_FFFF, 32'h0001_0001,
                           32'h0000_4000, 32'h0000_3FFF, 32'h0000_8000, 32'h0000_7FFF,
                           32'h0000_C000, 32'h0000_BFFF, 32'h0000_C001, 32'h0000_2000,
                           32'h0000_A000, 32'h0002_0000};
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int phase = 0; phase < PHASES; phase++)
        begin
            low    = pixels.range_low;
            recip  = pixels.span_recip;
            invert = pixels.invert_level;
            if (phase > 0)
            begin
                wait_for_results();
                case (phase)
                    1:
                    begin
                        low = 32'h8000_0000;
                        recip = 32'd1;
                        invert = 1'b0;
                    end
                    2:
                    begin
                        low = 32'h7FFF_FFFF;
                        recip = 32'hFFFF_FFFF;
                        invert = 1'b1;
                    end
                    3:
                    begin
                        low = $urandom;
                        recip = 32'd0;
                        invert = 1'b1;
                    end
                    default:
                    begin
                        low = $urandom;
                        shift = $urandom_range(12, 31);
                        span = (64'd1 << shift) + longint'($urandom_range(4095));
                        recip = 32'(64'h1_0000_0000 / span);
                        invert = phase[0];
                    end
                endcase
                write_register(dnr_pkg::CFG_RANGE_LOW, low);
                write_register(dnr_pkg::CFG_SPAN_RECIP, recip);
                write_register(dnr_pkg::CFG_INVERT_LEVEL, {$urandom_range(1) ? 31'h7FFF_FFFF : 31'd0, invert});
                if (phase == 1 || phase == 6)
                    write_register(CFG_NO_REGISTER, $urandom);
            end

            case (phase % 4)
                0:
                begin
                    sender_idle_pct = 0;
                    receiver_stall_pct = 0;
                end
                1:
                begin
                    sender_idle_pct = 52;
                    receiver_stall_pct = 0;
                end
                2:
                begin
                    sender_idle_pct = 0;
                    receiver_stall_pct = 52;
                end
                default:
                begin
                    sender_idle_pct = 33;
                    receiver_stall_pct = 33;
                end
            endcase

            if (phase == 0)
                foreach (corner_samples[i])
                    send_sample(corner_samples[i]);
            else
            begin
                send_sample(low);
                send_sample(low + 32'd1);
                send_sample(low - 32'd1);
            end

            span = (recip == 32'd0) ? (64'd1 << 20) : (64'h1_0000_0000 / recip);
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                if (phase == 5 && i == ITEMS_PER_PHASE / 2)
                    wait_for_results();
                send_sample(pick_sample(low, span));
            end
        end

        wait_for_results();
        if (pixels.mismatches == 0 && pixels.pending() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
